// ===== sv/csr_symmetric_diagonal_scaling_top_assert.svh =====
// Assertion macros for the diagonal scaling block.
// Both sample on aclk and are off while aresetn is low.
`ifndef CSR_SYMMETRIC_DIAGONAL_SCALING_TOP_ASSERT_SVH
`define CSR_SYMMETRIC_DIAGONAL_SCALING_TOP_ASSERT_SVH

// Same-cycle implication.
`define CSDS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CSDS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/csds_pkg.sv =====
package csds_pkg;

    localparam int MAX_ROWS = 1024;
    localparam int ADDR_W   = $clog2(MAX_ROWS);
    localparam int ROW_W    = 10;
    localparam int VAL_W    = 32;
    localparam int CNT_W    = 11;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic [CNT_W-1:0] ROW_COUNT_RESET = 11'd1024;

    // Register index, taken from paddr[2]
    localparam logic REG_ROW_COUNT = 1'b0;

    typedef enum logic [1:0] {
        CMD_CAPTURE   = 2'd0,
        CMD_SCALE     = 2'd1,
        CMD_PRECOND   = 2'd2,
        CMD_UNPRECOND = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STATUS_OK  = 2'd0,
        STATUS_BAD = 2'd1,
        STATUS_SAT = 2'd2
    } status_t;

    typedef struct packed {
        cmd_t                    cmd;
        logic [ROW_W-1:0]        row;
        logic [ROW_W-1:0]        col;
        logic signed [VAL_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] result_value;
        status_t                 status;
    } out_item_t;

endpackage

// ===== sv/csds_ram.sv =====
module csds_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/csr_symmetric_diagonal_scaling_top.sv =====
// Capture: taken in IDLE, no result, block stays in IDLE. Range errors go from IDLE
// to FINISH, diagonal errors from RD_ROW or RD_COL. Scale: RD_ROW, RD_COL, SQRT, DIV,
// FINISH; precondition skips RD_COL; unprecondition too, with MUL in place of DIV.
// No new item is taken until FINISH registers the result. 31 square-root and 48 divide
// steps share one subtract-compare unit, plus one shared 32x32 multiplier. Reset (aresetn,
// synchronous, active low) sets row_count to 1024 and zeroes the store with s_ready low.
`include "csr_symmetric_diagonal_scaling_top_assert.svh"

module csr_symmetric_diagonal_scaling_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  csds_pkg::in_item_t             s_item,
    output logic                           m_valid,
    input  logic                           m_ready,
    output csds_pkg::out_item_t            m_item,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [csds_pkg::PADDR_W-1:0]   paddr,
    input  logic [csds_pkg::PDATA_W-1:0]   pwdata,
    output logic [csds_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);

    import csds_pkg::*;

    localparam int SQRT_STEPS = 31;
    localparam int DIV_STEPS  = 48;

    typedef enum logic [2:0] {
        CLEAR,
        IDLE,
        RD_ROW,
        RD_COL,
        SQRT,
        DIV,
        MUL,
        FINISH
    } state_t;

    state_t            state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic [ROW_W-1:0]  col_reg, col_next;
    logic              neg_reg, neg_next;
    logic [31:0]       mag_reg, mag_next;
    logic              err_reg, err_next;
    logic [31:0]       dr_reg, dr_next;
    logic [61:0]       opnd_reg, opnd_next;
    logic [31:0]       rem_reg, rem_next;
    logic [30:0]       root_reg, root_next;
    logic [47:0]       q_reg, q_next;
    logic [5:0]        step_reg, step_next;
    logic [ADDR_W-1:0] clr_idx_reg, clr_idx_next;
    logic [CNT_W-1:0]  row_count_reg, row_count_next;
    logic              m_valid_reg, m_valid_next;
    out_item_t         out_reg, out_next;

    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic [31:0]       ram_wr_data;
    logic [ADDR_W-1:0] ram_rd_addr;
    logic [31:0]       rd_data;

    logic [33:0]       part;
    logic [33:0]       trial;
    logic [34:0]       diff;
    logic              ge;
    logic [31:0]       rem_new;

    logic [31:0]       mul_a, mul_b;
    logic [63:0]       prod;

    logic              accept;
    logic              row_ok, col_ok, range_ok;
    logic [31:0]       in_raw;
    logic [31:0]       in_mag;
    logic              rd_pos;
    logic [47:0]       limit;
    logic              cfg_wr;

    csds_ram #(
        .WIDTH(32),
        .DEPTH(MAX_ROWS)
    ) u_diag_ram (
        .aclk   (aclk),
        .wr_en  (ram_wr_en),
        .wr_addr(ram_wr_addr),
        .wr_data(ram_wr_data),
        .rd_addr(ram_rd_addr),
        .rd_data(rd_data)
    );

    assign s_ready = (state_reg == IDLE);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_item  = out_reg;
    assign pready  = 1'b1;
    assign prdata  = (paddr[2] == REG_ROW_COUNT) ? PDATA_W'(row_count_reg) : '0;
    assign cfg_wr  = psel && penable && pwrite && (paddr[2] == REG_ROW_COUNT);

    assign row_ok   = (32'(s_item.row) < 32'(row_count_reg)) &&
                      (32'(s_item.row) < 32'(MAX_ROWS));
    assign col_ok   = (32'(s_item.col) < 32'(row_count_reg)) &&
                      (32'(s_item.col) < 32'(MAX_ROWS));
    assign range_ok = row_ok && ((s_item.cmd != CMD_SCALE) || col_ok);
    assign in_raw   = s_item.value;
    assign in_mag   = in_raw[31] ? (~in_raw + 32'd1) : in_raw;
    assign rd_pos   = (rd_data != 32'd0) && !rd_data[31];

    // Store port: zero sweep after reset, diagonal captures afterwards
    assign ram_wr_en   = (state_reg == CLEAR) ||
                         (accept && (s_item.cmd == CMD_CAPTURE) &&
                          (s_item.row == s_item.col) && row_ok);
    assign ram_wr_addr = (state_reg == CLEAR) ? clr_idx_reg : ADDR_W'(s_item.row);
    assign ram_wr_data = (state_reg == CLEAR) ? 32'd0 : in_raw;
    assign ram_rd_addr = (state_reg == RD_ROW) ? ADDR_W'(col_reg) : ADDR_W'(s_item.row);

    // Shared subtract-compare: two bits per square-root step, one per divide step
    always_comb begin
        if (state_reg == SQRT) begin
            part  = {rem_reg, opnd_reg[61:60]};
            trial = {1'b0, root_reg, 2'b01};
        end else begin
            part  = {1'b0, rem_reg, opnd_reg[61]};
            trial = {3'b000, root_reg};
        end
        diff    = {1'b0, part} - {1'b0, trial};
        ge      = !diff[34];
        rem_new = ge ? diff[31:0] : part[31:0];
    end

    // Shared multiplier: d_row * d_col before the root, |v| * s after it
    always_comb begin
        mul_a = (state_reg == MUL) ? mag_reg : dr_reg;
        mul_b = (state_reg == MUL) ? {1'b0, root_reg} : rd_data;
        prod  = mul_a * mul_b;
    end

    assign limit = neg_reg ? 48'h0000_8000_0000 : 48'h0000_7FFF_FFFF;

    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        col_next       = col_reg;
        neg_next       = neg_reg;
        mag_next       = mag_reg;
        err_next       = err_reg;
        dr_next        = dr_reg;
        opnd_next      = opnd_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        q_next         = q_reg;
        step_next      = step_reg;
        clr_idx_next   = clr_idx_reg;
        row_count_next = cfg_wr ? pwdata[CNT_W-1:0] : row_count_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        out_next       = out_reg;

        unique case (state_reg)
            CLEAR: begin
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == ADDR_W'(MAX_ROWS - 1)) begin
                    state_next = IDLE;
                end
            end
            IDLE: begin
                if (s_valid) begin
                    cmd_next = s_item.cmd;
                    col_next = s_item.col;
                    neg_next = in_raw[31];
                    mag_next = in_mag;
                    err_next = 1'b0;
                    if (s_item.cmd != CMD_CAPTURE) begin
                        if (!range_ok) begin
                            err_next   = 1'b1;
                            state_next = FINISH;
                        end else begin
                            state_next = RD_ROW;
                        end
                    end
                end
            end
            RD_ROW: begin
                dr_next = rd_data;
                if (!rd_pos) begin
                    err_next   = 1'b1;
                    state_next = FINISH;
                end else if (cmd_reg == CMD_SCALE) begin
                    state_next = RD_COL;
                end else begin
                    opnd_next  = {15'd0, rd_data[30:0], 16'd0};
                    rem_next   = '0;
                    root_next  = '0;
                    step_next  = 6'(SQRT_STEPS - 1);
                    state_next = SQRT;
                end
            end
            RD_COL: begin
                if (!rd_pos) begin
                    err_next   = 1'b1;
                    state_next = FINISH;
                end else begin
                    opnd_next  = prod[61:0];
                    rem_next   = '0;
                    root_next  = '0;
                    step_next  = 6'(SQRT_STEPS - 1);
                    state_next = SQRT;
                end
            end
            SQRT: begin
                opnd_next = {opnd_reg[59:0], 2'b00};
                rem_next  = rem_new;
                root_next = {root_reg[29:0], ge};
                step_next = step_reg - 1'b1;
                if (step_reg == 6'd0) begin
                    if (cmd_reg == CMD_UNPRECOND) begin
                        state_next = MUL;
                    end else begin
                        // Numerator |v| * 2^16, top-aligned
                        opnd_next  = {mag_reg, 30'd0};
                        rem_next   = '0;
                        q_next     = '0;
                        step_next  = 6'(DIV_STEPS - 1);
                        state_next = DIV;
                    end
                end
            end
            DIV: begin
                opnd_next = {opnd_reg[60:0], 1'b0};
                rem_next  = rem_new;
                q_next    = {q_reg[46:0], ge};
                step_next = step_reg - 1'b1;
                if (step_reg == 6'd0) begin
                    state_next = FINISH;
                end
            end
            MUL: begin
                q_next     = prod[63:16];
                state_next = FINISH;
            end
            FINISH: begin
                // Hold until the output register is free or drains this cycle
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    state_next   = IDLE;
                    if (err_reg) begin
                        out_next.result_value = '0;
                        out_next.status       = STATUS_BAD;
                    end else if (q_reg > limit) begin
                        out_next.result_value = neg_reg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                        out_next.status       = STATUS_SAT;
                    end else begin
                        out_next.result_value = neg_reg ? (~q_reg[31:0] + 32'd1)
                                                        : q_reg[31:0];
                        out_next.status       = STATUS_OK;
                    end
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        cmd_reg  <= cmd_next;
        col_reg  <= col_next;
        neg_reg  <= neg_next;
        mag_reg  <= mag_next;
        err_reg  <= err_next;
        dr_reg   <= dr_next;
        opnd_reg <= opnd_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        q_reg    <= q_next;
        out_reg  <= out_next;
        if (!aresetn) begin
            state_reg     <= CLEAR;
            step_reg      <= '0;
            clr_idx_reg   <= '0;
            row_count_reg <= ROW_COUNT_RESET;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            clr_idx_reg   <= clr_idx_next;
            row_count_reg <= row_count_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    `CSDS_ASSERT_IMP(a_div_rem_below_divisor, state_reg == DIV,
        rem_reg < {1'b0, root_reg}, "divide remainder not below divisor")
    `CSDS_ASSERT_IMP(a_sqrt_rem_bound, state_reg == SQRT,
        {1'b0, rem_reg} <= {1'b0, root_reg, 1'b0}, "square-root remainder above twice the root")
    `CSDS_ASSERT_IMP(a_sat_value, m_valid && m_item.status == STATUS_SAT,
        m_item.result_value == 32'sh7FFF_FFFF || m_item.result_value == 32'sh8000_0000,
        "saturated result not at a range limit")
    `CSDS_ASSERT_IMP(a_bad_value_zero, m_valid && m_item.status == STATUS_BAD,
        m_item.result_value == 32'sd0, "flagged result not zero")
    `CSDS_ASSERT_NXT(a_capture_quiet, s_valid && s_ready && s_item.cmd == CMD_CAPTURE,
        state_reg == IDLE && !$rose(m_valid), "capture started work or a result")

endmodule

// ===== tb/tb_csr_symmetric_diagonal_scaling_top.sv =====
`timescale 1ns / 100ps

module tb_csr_symmetric_diagonal_scaling_top;
    import csds_pkg::*;

    localparam int DRAIN_CYCLES = 100;
    localparam int DRAIN_LIMIT  = 50000;
    localparam int PHASE_ITEMS  = 235;
    localparam int NUM_PHASES   = 8;

    typedef struct {
        bit                  is_cfg;
        logic [CNT_W-1:0]    cfg_rows;
        in_item_t            item;
        bit                  known;
        out_item_t           want;
    } dir_row_t;

    logic                 aclk;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    in_item_t             s_item  = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    out_item_t            m_item;
    logic                 psel    = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite  = 1'b0;
    logic [PADDR_W-1:0]   paddr   = '0;
    logic [PDATA_W-1:0]   pwdata  = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    // Local copy of the block state
    logic [VAL_W-1:0]     diag_copy [MAX_ROWS];
    logic [CNT_W-1:0]     row_count_copy = ROW_COUNT_RESET;

    out_item_t            pending_results [$];
    dir_row_t             directed_rows [$];

    int unsigned          send_idle_pct = 0;
    int unsigned          recv_stall_pct = 0;
    int unsigned          n_items = 0;
    int unsigned          n_checked = 0;
    int unsigned          n_errors = 0;

    csr_symmetric_diagonal_scaling_top u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #4000000;
        $display("%0t: timeout, %0d results still pending", $time, pending_results.size());
        $display("** csr_symmetric_diagonal_scaling_top: FAILED **");
        $finish;
    end

    initial begin
        for (int i = 0; i < MAX_ROWS; i++) diag_copy[i] = '0;
    end

    function automatic void flag_error(input string msg);
        $display("%0t: %s", $time, msg);
        n_errors++;
    endfunction

    // Floor of the square root, built one result bit at a time
    function automatic logic [63:0] floor_root(input logic [63:0] n);
        logic [63:0] r;
        logic [63:0] trial;
        r = '0;
        for (int i = 31; i >= 0; i--) begin
            trial = r | (64'd1 << i);
            if (trial * trial <= n) r = trial;
        end
        return r;
    endfunction

    // Returns 1 when the item yields a result; updates the diagonal copy on capture
    function automatic bit predict_scaled(input in_item_t it, output out_item_t res);
        logic [31:0]  raw;
        logic [31:0]  dr;
        logic [31:0]  dc;
        logic [63:0]  mag;
        logic [63:0]  s;
        logic [63:0]  q;
        logic [63:0]  lim;
        int unsigned  eff;
        bit           neg;
        raw = it.value;
        neg = raw[31];
        mag = neg ? (64'd1 << 32) - {32'd0, raw} : {32'd0, raw};
        eff = (row_count_copy < MAX_ROWS) ? row_count_copy : MAX_ROWS;
        res.result_value = '0;
        res.status = STATUS_BAD;
        if (it.cmd == CMD_CAPTURE) begin
            if (it.col == it.row && it.row < eff) diag_copy[it.row] = raw;
            return 1'b0;
        end
        if (it.row >= eff || (it.cmd == CMD_SCALE && it.col >= eff)) return 1'b1;
        dr = diag_copy[it.row];
        // vector commands scale by sqrt(d * 1.0)
        dc = (it.cmd == CMD_SCALE) ? diag_copy[it.col] : 32'h0001_0000;
        if (dr == 0 || dr[31] || dc == 0 || dc[31]) return 1'b1;
        s = floor_root({32'd0, dr} * {32'd0, dc});
        if (it.cmd == CMD_UNPRECOND) q = (mag * s) >> 16;
        else q = (mag << 16) / s;
        lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        if (q > lim) begin
            res.result_value = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
            res.status = STATUS_SAT;
        end else begin
            res.result_value = neg ? 32'(32'd0 - q[31:0]) : q[31:0];
            res.status = STATUS_OK;
        end
        return 1'b1;
    endfunction

    function automatic void add_row(input bit is_cfg, input int unsigned rows,
                                    input cmd_t c, input int unsigned r,
                                    input int unsigned cl, input logic [31:0] v,
                                    input bit known, input logic [31:0] wv,
                                    input status_t ws);
        dir_row_t d;
        d.is_cfg = is_cfg;
        d.cfg_rows = rows[CNT_W-1:0];
        d.item.cmd = c;
        d.item.row = r[ROW_W-1:0];
        d.item.col = cl[ROW_W-1:0];
        d.item.value = v;
        d.known = known;
        d.want.result_value = wv;
        d.want.status = ws;
        directed_rows.push_back(d);
    endfunction

    function automatic logic [ROW_W-1:0] pick_index(input int unsigned eff);
        int unsigned k;
        k = $urandom_range(0, 99);
        if (eff != 0 && k < 70) return ROW_W'($urandom_range(0, (eff < 12 ? eff : 12) - 1));
        if (eff != 0 && eff < MAX_ROWS && k < 80) return ROW_W'($urandom_range(eff - 1, eff));
        return ROW_W'($urandom_range(0, MAX_ROWS - 1));
    endfunction

    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        case ($urandom_range(0, 7))
            0: v = 32'h7FFF_FFFF;
            1: v = 32'h8000_0000;
            2: v = '0;
            3: begin
                v = $urandom_range(0, 32'h3_FFFF);
                if ($urandom_range(0, 1) == 1) v = 32'd0 - v;
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic in_item_t make_item();
        in_item_t    it;
        int unsigned eff;
        int unsigned k;
        eff = (row_count_copy < MAX_ROWS) ? row_count_copy : MAX_ROWS;
        k = $urandom_range(0, 99);
        if (k < 22) begin
            it.cmd = CMD_CAPTURE;
            it.row = pick_index(eff);
            it.col = (k < 18) ? it.row : pick_index(eff);
            case ($urandom_range(0, 9))
                0: it.value = '0;
                1: it.value = {1'b1, 31'($urandom)};
                default: it.value = $urandom >> $urandom_range(1, 31);
            endcase
        end else begin
            case ($urandom_range(0, 2))
                0: it.cmd = CMD_SCALE;
                1: it.cmd = CMD_PRECOND;
                default: it.cmd = CMD_UNPRECOND;
            endcase
            it.row = pick_index(eff);
            it.col = (it.cmd == CMD_SCALE) ? pick_index(eff) : 10'($urandom);
            it.value = pick_value();
        end
        return it;
    endfunction

    task automatic csr_write(input logic [CNT_W-1:0] rows);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_ROW_COUNT, 2'b00};
        pwdata <= {{(PDATA_W-CNT_W){1'b0}}, rows};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        row_count_copy = rows;
        @(posedge aclk);
    endtask

    task automatic csr_read_check(input logic [CNT_W-1:0] rows);
        logic [PDATA_W-1:0] want;
        want = {{(PDATA_W-CNT_W){1'b0}}, rows};
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {REG_ROW_COUNT, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        if (prdata !== want)
            flag_error($sformatf("row_count read: expected %h, actual %h", want, prdata));
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // Hold until every expected result is back, then let the block settle
    task automatic drain_results();
        int unsigned waited;
        waited = 0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        if (pending_results.size() != 0)
            flag_error($sformatf("%0d results never arrived", pending_results.size()));
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic send_item(input in_item_t it, input bit known, input out_item_t want);
        out_item_t res;
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item <= it;
        do @(posedge aclk); while (s_ready !== 1'b1);
        // transfer taken at this edge
        if (predict_scaled(it, res)) pending_results.push_back(known ? want : res);
        n_items++;
    endtask

    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (pending_results.size() == 0) begin
                flag_error($sformatf("unexpected result %h status %0d",
                                     m_item.result_value, m_item.status));
            end else begin
                out_item_t exp_res;
                exp_res = pending_results.pop_front();
                if (m_item.result_value !== exp_res.result_value)
                    flag_error($sformatf("result_value: expected %h, actual %h",
                                         exp_res.result_value, m_item.result_value));
                if (m_item.status !== exp_res.status)
                    flag_error($sformatf("status: expected %0d, actual %0d",
                                         exp_res.status, m_item.status));
                n_checked++;
            end
        end
        m_ready <= (recv_stall_pct != 0 && $urandom_range(0, 99) < recv_stall_pct) ? 1'b0
                                                                                  : 1'b1;
    end

    initial begin : stimulus
        logic [CNT_W-1:0] phase_rows [NUM_PHASES];
        int unsigned      idle_mode;
        out_item_t        none;

        phase_rows = '{11'd1024, 11'd1, 11'd0, 11'd2047, 11'd5, 11'd1023, 11'd64, 11'd1024};
        none = '0;

        add_row(0, 0, CMD_SCALE,     0,    0,    32'h0001_0000, 1, 32'h0, STATUS_BAD);
        add_row(0, 0, CMD_PRECOND,   5,    0,    32'h0001_0000, 1, 32'h0, STATUS_BAD);
        add_row(0, 0, CMD_CAPTURE,   0,    0,    32'h0001_0000, 0, 32'h0, STATUS_OK);
        add_row(0, 0, CMD_CAPTURE,   1,    1,    32'h0004_0000, 0, 32'h0, STATUS_OK);
        add_row(0, 0, CMD_CAPTURE,   2,    3,    32'h0001_0000, 0, 32'h0, STATUS_OK);
        add_row(0, 0, CMD_SCALE,     2,    2,    32'h0001_0000, 1, 32'h0, STATUS_BAD);
        add_row(0, 0, CMD_SCALE,     0,    0,    32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, STATUS_OK);
        add_row(0, 0, CMD_SCALE,     0,    0,    32'h8000_0000, 1, 32'h8000_0000, STATUS_OK);
        add_row(0, 0, CMD_PRECOND,   1,    1023, 32'h7FFF_FFFF, 0, 32'h0, STATUS_OK);
        add_row(0, 0, CMD_UNPRECOND, 1,    0,    32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, STATUS_SAT);
        add_row(0, 0, CMD_UNPRECOND, 1,    0,    32'h8000_0000, 1, 32'h8000_0000, STATUS_SAT);
        add_row(0, 0, CMD_CAPTURE,   4,    4,    32'h0000_0001, 0, 32'h0, STATUS_OK);
        add_row(0, 0, CMD_PRECOND,   4,    0,    32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, STATUS_SAT);
        add_row(0, 0, CMD_CAPTURE,   5,    5,    32'h8000_0000, 0, 32'h0, STATUS_OK);
        add_row(0, 0, CMD_SCALE,     5,    0,    32'h0001_0000, 1, 32'h0, STATUS_BAD);
        add_row(0, 0, CMD_CAPTURE,   6,    6,    32'h7FFF_FFFF, 0, 32'h0, STATUS_OK);
        add_row(0, 0, CMD_SCALE,     6,    1,    32'hFFFF_FFFF, 0, 32'h0, STATUS_OK);
        add_row(0, 0, CMD_SCALE,     1,    0,    32'h0001_0000, 0, 32'h0, STATUS_OK);
        add_row(0, 0, CMD_PRECOND,   1,    0,    32'h0,         1, 32'h0, STATUS_OK);
        add_row(0, 0, CMD_CAPTURE,   1023, 1023, 32'h0003_0000, 0, 32'h0, STATUS_OK);
        add_row(0, 0, CMD_SCALE,     1023, 6,    32'h1234_5678, 0, 32'h0, STATUS_OK);
        // shrink the matrix: index two falls out of range
        add_row(1, 2, CMD_CAPTURE,   0,    0,    32'h0,         0, 32'h0, STATUS_OK);
        add_row(0, 0, CMD_CAPTURE,   2,    2,    32'h0001_0000, 0, 32'h0, STATUS_OK);
        add_row(0, 0, CMD_SCALE,     0,    2,    32'h0001_0000, 1, 32'h0, STATUS_BAD);
        add_row(0, 0, CMD_PRECOND,   2,    0,    32'h0001_0000, 1, 32'h0, STATUS_BAD);
        // the out-of-range capture must have stored nothing
        add_row(1, 1024, CMD_CAPTURE, 0,   0,    32'h0,         0, 32'h0, STATUS_OK);
        add_row(0, 0, CMD_PRECOND,   2,    0,    32'h0001_0000, 1, 32'h0, STATUS_BAD);

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // diagonal store clearing pass
        while (s_ready !== 1'b1) @(posedge aclk);
        csr_read_check(ROW_COUNT_RESET);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].is_cfg) begin
                s_valid <= 1'b0;
                drain_results();
                csr_write(directed_rows[i].cfg_rows);
                csr_read_check(directed_rows[i].cfg_rows);
            end else begin
                send_item(directed_rows[i].item, directed_rows[i].known,
                          directed_rows[i].want);
            end
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            s_valid <= 1'b0;
            drain_results();
            csr_write(phase_rows[p]);
            csr_read_check(phase_rows[p]);
            idle_mode = p % 4;
            case (idle_mode)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
                default: begin send_idle_pct = 26; recv_stall_pct = 26; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) send_item(make_item(), 1'b0, none);
        end

        s_valid <= 1'b0;
        recv_stall_pct = 0;
        drain_results();

        $display("Sent %0d items and checked %0d results across %0d row-count settings,",
                 n_items, n_checked, NUM_PHASES + 3);
        $display("with idle-free, sender-idle, receiver-stall and mixed pacing.");
        if (n_errors == 0) begin
            $display("** csr_symmetric_diagonal_scaling_top: PASSED **");
        end else begin
            $display("%0d errors", n_errors);
            $display("** csr_symmetric_diagonal_scaling_top: FAILED **");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/csds_pkg.sv
sv/csds_ram.sv
sv/csr_symmetric_diagonal_scaling_top.sv
tb/tb_csr_symmetric_diagonal_scaling_top.sv
